// ===== hdl/lidar_range_image_projection_top_defines.svh =====
// assertion macros for the lidar projection checker
`ifndef LIDAR_RANGE_IMAGE_PROJECTION_TOP_DEFINES_SVH
`define LIDAR_RANGE_IMAGE_PROJECTION_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define LRIP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrip check failed");

// next-cycle implication, sampled on clk, off during rst
`define LRIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrip check failed");

`endif

// ===== hdl/lrip_pkg.sv =====
// shared types, codes and the cordic angle table for the lidar projection block
`timescale 1ns / 1ps
package lrip_pkg;

  localparam int CORDIC_STEPS = 28;

  localparam logic [2:0] ST_ACCEPT    = 3'd0;
  localparam logic [2:0] ST_RANGE_OUT = 3'd1;
  localparam logic [2:0] ST_ROW_OUT   = 3'd2;
  localparam logic [2:0] ST_COL_OUT   = 3'd3;
  localparam logic [2:0] ST_TAKEN     = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  localparam logic [1:0] CFG_MIN_RANGE = 2'd0;
  localparam logic [1:0] CFG_MAX_RANGE = 2'd1;
  localparam logic [1:0] CFG_ROWS      = 2'd2;

  // one classified request between front and back
  typedef struct packed {
    logic        clr;
    logic [2:0]  status;
    logic [6:0]  row;
    logic [11:0] column;
    logic [18:0] flat;
    logic [19:0] range_mm;
    logic [7:0]  intensity;
  } lrip_item_t;

  // atan(2^-i) in turn units, 2^32 per turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lrip_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
module lrip_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 115200
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/lrip_queue.sv =====
// short request queue between the front and back parts
`timescale 1ns / 1ps
module lrip_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lrip_pkg::lrip_item_t din,
  output logic               full,
  input  logic               pop,
  output lrip_pkg::lrip_item_t dout,
  output logic               empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lrip_pkg::lrip_item_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lrip_front.sv =====
// front part: range, sqrt, cordic angle and column, classification
`timescale 1ns / 1ps
module lrip_front #(
  parameter int MAX_ROWS = 64,
  parameter int COLUMNS  = 1800
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 hold,
  output logic                 busy,
  input  logic                 action,
  input  logic signed [19:0]   pos_x,
  input  logic signed [19:0]   pos_y,
  input  logic signed [19:0]   pos_z,
  input  logic [15:0]          ring,
  input  logic [7:0]           intensity,
  input  logic [19:0]          min_range,
  input  logic [19:0]          max_range,
  input  logic [6:0]           rows_in_use,
  input  logic                 q_full,
  output logic                 q_push,
  output lrip_pkg::lrip_item_t q_data
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ   = 3'd1;
  localparam logic [2:0] F_SQRT = 3'd2;
  localparam logic [2:0] F_CHK  = 3'd3;
  localparam logic [2:0] F_ROT  = 3'd4;
  localparam logic [2:0] F_COL  = 3'd5;
  localparam logic [2:0] F_RND  = 3'd6;
  localparam logic [2:0] F_PUSH = 3'd7;

  localparam logic signed [15:0] COLS_S    = 16'(COLUMNS);
  localparam logic signed [15:0] HALF_COLS = 16'(COLUMNS / 2);
  localparam logic signed [13:0] COLS_M    = 14'(COLUMNS);
  localparam logic signed [47:0] HALF_T    = 48'sh0000_8000_0000;
  localparam logic signed [33:0] TURN_HALF = 34'sh0_8000_0000;
  localparam logic signed [33:0] TURN_FULL = 34'sh1_0000_0000;

  logic [2:0]  state;
  logic [4:0]  step;
  logic signed [19:0] px;
  logic signed [19:0] py;
  logic [19:0] ax;
  logic [19:0] ay;
  logic [19:0] az;
  logic [15:0] ring_r;
  logic [39:0] prod;
  logic [39:0] sq_sum;
  logic [39:0] lo_sq;
  logic [39:0] hi_sq;
  logic [39:0] sbits;
  logic [19:0] root;
  logic [22:0] rem;
  logic signed [43:0] cx;
  logic signed [43:0] cy;
  logic signed [33:0] acc;
  logic signed [47:0] tprod;
  lrip_pkg::lrip_item_t ent;

  logic [19:0] mul_a;
  logic [22:0] rem_sh;
  logic [22:0] trial;
  logic [19:0] range_rnd;
  logic signed [43:0] dx;
  logic signed [43:0] dy;
  logic signed [33:0] acc_w;
  logic signed [34:0] angle_off;
  logic signed [47:0] tpos;
  logic signed [47:0] tneg;
  logic signed [15:0] q;
  logic signed [15:0] col_raw;
  logic signed [15:0] col_w;
  logic signed [43:0] cx0;
  logic signed [43:0] cy0;
  lrip_pkg::lrip_item_t ent_init;

  assign busy   = (state != F_IDLE);
  assign q_push = (state == F_PUSH);
  assign q_data = ent;

  // request as taken: a clear is complete, a point keeps its intensity
  always_comb begin
    ent_init     = '0;
    ent_init.clr = action;
    if (action) begin
      ent_init.status = lrip_pkg::ST_CLEARED;
    end else begin
      ent_init.intensity = intensity;
    end
  end

  always_comb begin
    case (step)
      5'd0:    mul_a = ax;
      5'd1:    mul_a = ay;
      5'd2:    mul_a = az;
      5'd3:    mul_a = min_range;
      5'd4:    mul_a = max_range;
      default: mul_a = '0;
    endcase
  end

  // one bit of the root per cycle
  assign rem_sh    = {rem[20:0], sbits[39:38]};
  assign trial     = {1'b0, root, 2'b01};
  assign range_rnd = (rem > {3'b0, root}) ? root + 1'b1 : root;

  assign cx0 = {{4{py[19]}}, py, 20'b0};
  assign cy0 = {{4{px[19]}}, px, 20'b0};
  assign dx  = cy >>> step;
  assign dy  = cx >>> step;

  always_comb begin
    if (acc >= TURN_HALF) begin
      acc_w = acc - TURN_FULL;
    end else if (acc < -TURN_HALF) begin
      acc_w = acc + TURN_FULL;
    end else begin
      acc_w = acc;
    end
  end

  assign angle_off = 35'(acc_w) - 35'sh0_4000_0000;
  assign tpos      = tprod + HALF_T;
  assign tneg      = HALF_T - tprod;
  assign q         = (tprod >= 0) ? 16'(tpos >>> 32) : -16'(tneg >>> 32);
  assign col_raw   = HALF_COLS - q;
  assign col_w     = (col_raw >= COLS_S) ? col_raw - COLS_S : col_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (push && !hold) begin
            px     <= pos_x;
            py     <= pos_y;
            ax     <= pos_x[19] ? 20'(-pos_x) : pos_x;
            ay     <= pos_y[19] ? 20'(-pos_y) : pos_y;
            az     <= pos_z[19] ? 20'(-pos_z) : pos_z;
            ring_r <= ring;
            step   <= '0;
            ent    <= ent_init;
            state  <= action ? F_PUSH : F_SQ;
          end
        end
        F_SQ: begin
          prod <= mul_a * mul_a;
          case (step)
            5'd1:    sq_sum <= prod;
            5'd2:    sq_sum <= sq_sum + prod;
            5'd3:    sq_sum <= sq_sum + prod;
            5'd4:    lo_sq <= prod;
            5'd5:    hi_sq <= prod;
            default: ;
          endcase
          if (step == 5'd5) begin
            step  <= '0;
            sbits <= sq_sum;
            rem   <= '0;
            root  <= '0;
            state <= F_SQRT;
          end else begin
            step <= step + 1'b1;
          end
        end
        F_SQRT: begin
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[18:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[18:0], 1'b0};
          end
          sbits <= {sbits[37:0], 2'b00};
          if (step == 5'd19) begin
            step  <= '0;
            state <= F_CHK;
          end else begin
            step <= step + 1'b1;
          end
        end
        F_CHK: begin
          ent.range_mm <= range_rnd;
          step         <= '0;
          if (sq_sum < lo_sq || sq_sum > hi_sq) begin
            ent.status <= lrip_pkg::ST_RANGE_OUT;
            state      <= F_PUSH;
          end else if (ring_r >= {9'b0, rows_in_use} || ring_r >= 16'(MAX_ROWS)) begin
            ent.status <= lrip_pkg::ST_ROW_OUT;
            state      <= F_PUSH;
          end else if (px == '0 && py == '0) begin
            acc   <= '0;
            state <= F_COL;
          end else if (py[19]) begin
            acc   <= px[19] ? -TURN_HALF : TURN_HALF;
            cx    <= -cx0;
            cy    <= -cy0;
            state <= F_ROT;
          end else begin
            acc   <= '0;
            cx    <= cx0;
            cy    <= cy0;
            state <= F_ROT;
          end
        end
        F_ROT: begin
          if (cy > 0) begin
            cx  <= cx + dx;
            cy  <= cy - dy;
            acc <= acc + $signed({4'b0, lrip_pkg::atan_turn(step)});
          end else begin
            cx  <= cx - dx;
            cy  <= cy + dy;
            acc <= acc - $signed({4'b0, lrip_pkg::atan_turn(step)});
          end
          if (step == 5'(lrip_pkg::CORDIC_STEPS - 1)) begin
            step  <= '0;
            state <= F_COL;
          end else begin
            step <= step + 1'b1;
          end
        end
        F_COL: begin
          tprod <= 48'(angle_off) * 48'(COLS_M);
          state <= F_RND;
        end
        F_RND: begin
          if (col_w < 0 || col_w >= COLS_S) begin
            ent.status <= lrip_pkg::ST_COL_OUT;
          end else begin
            ent.status <= lrip_pkg::ST_ACCEPT;
            ent.row    <= ring_r[6:0];
            ent.column <= col_w[11:0];
            ent.flat   <= 19'(col_w[11:0]) + 19'(ring_r[6:0]) * 19'(COLUMNS);
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lrip_back.sv =====
// back part: occupancy map lookup, marking, clearing and the result register
`timescale 1ns / 1ps
module lrip_back #(
  parameter int MAX_ROWS = 64,
  parameter int COLUMNS  = 1800
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  lrip_pkg::lrip_item_t q_head,
  output logic                 q_pop,
  output logic                 clearing,
  output lrip_pkg::lrip_item_t res,
  output logic                 res_valid,
  input  logic                 res_pop
);

  localparam int DEPTH = MAX_ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] B_SWEEP = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_LOOK  = 2'd2;

  logic [1:0]  state;
  logic [AW-1:0] sweep_addr;
  logic        report;
  logic        boot;
  lrip_pkg::lrip_item_t cur;
  lrip_pkg::lrip_item_t cur_taken;

  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [0:0]    ram_wdata;
  logic [0:0]    ram_rdata;
  logic          take;

  assign take     = (state == B_IDLE) && !q_empty && !res_valid;
  assign q_pop    = take;
  assign clearing = boot;

  // same point reported as landing on an occupied cell
  always_comb begin
    cur_taken        = cur;
    cur_taken.status = lrip_pkg::ST_TAKEN;
    cur_taken.row    = '0;
    cur_taken.column = '0;
    cur_taken.flat   = '0;
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(q_head.flat);
    ram_wdata = 1'b0;
    case (state)
      B_SWEEP: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = sweep_addr;
      end
      B_IDLE: begin
        ram_en = take && !q_head.clr && (q_head.status == lrip_pkg::ST_ACCEPT);
      end
      B_LOOK: begin
        ram_addr  = AW'(cur.flat);
        ram_en    = !ram_rdata[0];
        ram_we    = !ram_rdata[0];
        ram_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  lrip_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_SWEEP;
      sweep_addr <= '0;
      report     <= 1'b0;
      boot       <= 1'b1;
      res_valid  <= 1'b0;
    end else begin
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_SWEEP: begin
          if (sweep_addr == AW'(DEPTH - 1)) begin
            sweep_addr <= '0;
            boot       <= 1'b0;
            state      <= B_IDLE;
            if (report) begin
              res       <= cur;
              res_valid <= 1'b1;
            end
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        B_IDLE: begin
          if (take) begin
            cur <= q_head;
            if (q_head.clr) begin
              report <= 1'b1;
              state  <= B_SWEEP;
            end else if (q_head.status != lrip_pkg::ST_ACCEPT) begin
              res       <= q_head;
              res_valid <= 1'b1;
            end else begin
              state <= B_LOOK;
            end
          end
        end
        B_LOOK: begin
          res       <= ram_rdata[0] ? cur_taken : cur;
          res_valid <= 1'b1;
          state     <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lidar_range_image_projection_top.sv =====
// top level of the lidar range image projection block
// usage:
//   input channel: a request is taken at a clock edge with push high and full low;
//   action 0 projects one point (pos_x, pos_y, pos_z, ring, intensity), action 1
//   clears the occupancy map for a new frame
//   result channel: while empty is low the oldest result sits on status, row,
//   column, cell_index, range_mm and intensity_out; pop takes it
//   config channel: cfg_ready is always high; cfg_index 0 min range, 1 max range,
//   2 rows in use, other indexes are ignored
// timing:
//   a projected point keeps the front part busy through the multiply, sqrt, check,
//   cordic, column and hand-off steps; full stays high until the hand-off, so a new
//   point is taken only once the last is queued; range or row rejects skip the
//   cordic and column steps, the zero vector only the cordic; the back part
//   registers a reject as it takes it, and for a point reads the map cell, then
//   marks it and registers the result; a clear request sweeps all MAX_ROWS*COLUMNS
//   map cells (115200 at the defaults) one cell per cycle; points may queue meanwhile
// reset: rst clears control state and starts the same map sweep; full stays high
//   until it is done
// stall: a result not popped holds the back part, the queue fills, then the
//   front part holds its finished request and full stays high
`timescale 1ns / 1ps
module lidar_range_image_projection_top #(
  parameter int MAX_ROWS = 64,
  parameter int COLUMNS  = 1800
) (
  input  logic               clk,
  input  logic               rst,
  // point and clear requests
  input  logic               push,
  output logic               full,
  input  logic               action,
  input  logic signed [19:0] pos_x,
  input  logic signed [19:0] pos_y,
  input  logic signed [19:0] pos_z,
  input  logic [15:0]        ring,
  input  logic [7:0]         intensity,
  // results
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic [5:0]         row,
  output logic [10:0]        column,
  output logic [16:0]        cell_index,
  output logic [19:0]        range_mm,
  output logic [7:0]         intensity_out,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  logic [19:0] min_range;
  logic [19:0] max_range;
  logic [6:0]  rows_in_use;

  logic                 front_busy;
  logic                 clearing;
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  lrip_pkg::lrip_item_t q_din;
  lrip_pkg::lrip_item_t q_head;
  lrip_pkg::lrip_item_t res;
  logic                 res_valid;

  // config registers, writable any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range   <= 20'd1000;
      max_range   <= 20'd200000;
      rows_in_use <= 7'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrip_pkg::CFG_MIN_RANGE: min_range   <= cfg_data;
        lrip_pkg::CFG_MAX_RANGE: max_range   <= cfg_data;
        lrip_pkg::CFG_ROWS:      rows_in_use <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // no new request while the front part is busy or during the reset sweep
  assign full = front_busy || clearing;

  lrip_front #(
    .MAX_ROWS(MAX_ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .hold       (clearing),
    .busy       (front_busy),
    .action     (action),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .ring       (ring),
    .intensity  (intensity),
    .min_range  (min_range),
    .max_range  (max_range),
    .rows_in_use(rows_in_use),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_din)
  );

  // decouples the arithmetic from the map access
  lrip_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_head),
    .empty(q_empty)
  );

  lrip_back #(
    .MAX_ROWS(MAX_ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .res      (res),
    .res_valid(res_valid),
    .res_pop  (pop)
  );

  // result ports straight from the back part's output register
  assign empty         = !res_valid;
  assign status        = res.status;
  assign row           = res.row[5:0];
  assign column        = res.column[10:0];
  assign cell_index    = res.flat[16:0];
  assign range_mm      = res.range_mm;
  assign intensity_out = res.intensity;

endmodule

// ===== hdl/lrip_checker.sv =====
// port-level checker for the lidar projection block and its bind
`timescale 1ns / 1ps
`include "lidar_range_image_projection_top_defines.svh"
module lrip_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  status,
  input logic [5:0]  row,
  input logic [10:0] column,
  input logic [16:0] cell_index,
  input logic [19:0] range_mm,
  input logic [7:0]  intensity_out
);

  `LRIP_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(status) && $stable(cell_index))
  `LRIP_ASSERT_NOW(a_status_code, !empty, status <= lrip_pkg::ST_CLEARED)
  `LRIP_ASSERT_NOW(a_reject_zero, !empty && status != lrip_pkg::ST_ACCEPT, row == '0 && column == '0 && cell_index == '0)
  `LRIP_ASSERT_NOW(a_clear_zero, !empty && status == lrip_pkg::ST_CLEARED, range_mm == '0 && intensity_out == '0)

endmodule

bind lidar_range_image_projection_top lrip_checker u_lrip_checker (.*);
